[rtl/psm_pkg.sv]
// ----------------------------------------------------------------------------
// psm_pkg: shared types and constants of the P-code stack machine
// Opcodes, status codes, register indexes and the control/status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package psm_pkg;

   // Opcodes
   localparam logic [4:0] OP_LDA   = 5'd0;
   localparam logic [4:0] OP_LDV   = 5'd1;
   localparam logic [4:0] OP_LDC   = 5'd2;
   localparam logic [4:0] OP_SUP   = 5'd3;
   localparam logic [4:0] OP_SUPE  = 5'd4;
   localparam logic [4:0] OP_INF   = 5'd5;
   localparam logic [4:0] OP_INFE  = 5'd6;
   localparam logic [4:0] OP_EG    = 5'd7;
   localparam logic [4:0] OP_DIFF  = 5'd8;
   localparam logic [4:0] OP_AND   = 5'd9;
   localparam logic [4:0] OP_OR    = 5'd10;
   localparam logic [4:0] OP_NOT   = 5'd11;
   localparam logic [4:0] OP_JMP   = 5'd12;
   localparam logic [4:0] OP_JIF   = 5'd13;
   localparam logic [4:0] OP_TSR   = 5'd14;
   localparam logic [4:0] OP_RSR   = 5'd15;
   localparam logic [4:0] OP_ADD   = 5'd16;
   localparam logic [4:0] OP_MOINS = 5'd17;
   localparam logic [4:0] OP_DIV   = 5'd18;
   localparam logic [4:0] OP_MULT  = 5'd19;
   localparam logic [4:0] OP_NEG   = 5'd20;
   localparam logic [4:0] OP_INC   = 5'd21;
   localparam logic [4:0] OP_DEC   = 5'd22;
   localparam logic [4:0] OP_RD    = 5'd23;
   localparam logic [4:0] OP_RDLN  = 5'd24;
   localparam logic [4:0] OP_WRT   = 5'd25;
   localparam logic [4:0] OP_WRTLN = 5'd26;
   localparam logic [4:0] OP_AFF   = 5'd27;

   // Status codes
   localparam logic [2:0] ST_RUN         = 3'd0;
   localparam logic [2:0] ST_CLEAN       = 3'd1;
   localparam logic [2:0] ST_BAD_STACK   = 3'd2;
   localparam logic [2:0] ST_BAD_CODE    = 3'd3;
   localparam logic [2:0] ST_BAD_BOTH    = 3'd4;
   localparam logic [2:0] ST_STACK_FAULT = 3'd5;
   localparam logic [2:0] ST_DIV_ZERO    = 3'd6;

   // Register indexes
   localparam logic [7:0] CSR_NUM_VARIABLES  = 8'd0;
   localparam logic [7:0] CSR_PROGRAM_LENGTH = 8'd1;

   // Variable slot fill value (-666)
   localparam logic [31:0] VAR_INIT = 32'hFFFF_FD66;

   // Commands from the controller
   typedef struct packed {
      logic load;       // latch the accepted instruction
      logic rd1;        // read first stack word
      logic rd2;        // capture first word, read second
      logic cap_b;      // capture second word
      logic div_start;  // launch the divider
      logic commit;     // retire: write back, load the result register
   } ctrl_cmd_type;

   // Status toward the controller
   typedef struct packed {
      logic fill_busy;
      logic op_is_div;
      logic div_busy;
      logic out_free;
   } dp_status_type;

endpackage

[rtl/psm_div.sv]
// ----------------------------------------------------------------------------
// psm_div: iterative signed divider
// Restoring divide on magnitudes, one quotient bit per cycle, quotient
// truncated toward zero and wrapping for the most negative value over -1.
// ----------------------------------------------------------------------------
module psm_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic [31:0] quotient
);

   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dsr_ff, dsr_in;
   logic        neg_ff, neg_in;
   logic [32:0] trial;

   // One shift-subtract step a cycle
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      trial   = {rem_ff, quo_ff[31]} - {1'b0, dsr_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd32;
         rem_in  = 32'd0;
         quo_in  = dividend[31] ? 32'd0 - dividend : dividend;
         dsr_in  = divisor[31] ? 32'd0 - divisor : divisor;
         neg_in  = dividend[31] ^ divisor[31];
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
         end
         quo_in = {quo_ff[30:0], ~trial[32]};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
   end

   assign busy     = busy_ff;
   assign quotient = neg_ff ? 32'd0 - quo_ff : quo_ff;

endmodule

[rtl/psm_ctrl.sv]
// ----------------------------------------------------------------------------
// psm_ctrl: instruction sequencer
// Steps each instruction through two stack reads, an optional divide and a
// retire cycle that waits for a free result register.
// ----------------------------------------------------------------------------
module psm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  psm_pkg::dp_status_type  status,
   output psm_pkg::ctrl_cmd_type   cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RA   = 3'd1;
   localparam logic [2:0] S_RB   = 3'd2;
   localparam logic [2:0] S_RC   = 3'd3;
   localparam logic [2:0] S_DIVS = 3'd4;
   localparam logic [2:0] S_DIVW = 3'd5;
   localparam logic [2:0] S_WB   = 3'd6;

   logic [2:0] state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = !status.fill_busy;
            if (req_tvalid && !status.fill_busy) begin
               cmd.load = 1'b1;
               state_in = S_RA;
            end
         end
         S_RA: begin
            cmd.rd1  = 1'b1;
            state_in = S_RB;
         end
         S_RB: begin
            cmd.rd2  = 1'b1;
            state_in = S_RC;
         end
         S_RC: begin
            cmd.cap_b = 1'b1;
            state_in  = status.op_is_div ? S_DIVS : S_WB;
         end
         S_DIVS: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIVW;
         end
         S_DIVW: begin
            if (!status.div_busy) begin
               state_in = S_WB;
            end
         end
         S_WB: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/psm_dpath.sv]
// ----------------------------------------------------------------------------
// psm_dpath: stack machine datapath
// Stack memory, stack pointer, pc, configuration, execute logic, variable
// fill sweep and the result register.
// ----------------------------------------------------------------------------
module psm_dpath #(
   parameter int STACK_DEPTH = 256,
   parameter int PROG_DEPTH  = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  psm_pkg::ctrl_cmd_type  cmd,
   output psm_pkg::dp_status_type status,
   input  logic [4:0]             req_opcode,
   input  logic signed [31:0]     req_operand,
   input  logic signed [31:0]     req_read_value,
   input  logic                   csr_write,
   input  logic [7:0]             csr_index,
   input  logic [15:0]            csr_data,
   input  logic                   rsp_tready,
   output logic                   rsp_valid,
   output logic [12:0]            rsp_next_pc,
   output logic                   rsp_write_valid,
   output logic signed [31:0]     rsp_write_value,
   output logic                   rsp_newline,
   output logic [2:0]             rsp_status
);

   localparam int AW  = $clog2(STACK_DEPTH);
   localparam int SPW = $clog2(STACK_DEPTH + 1);

   logic [31:0]    mem [STACK_DEPTH];
   logic [31:0]    rdata_ff;
   logic [AW-1:0]  rd_addr;

   logic [4:0]     op_ff;
   logic [31:0]    opd_ff, rv_ff, a_ff, b_ff;

   logic [SPW-1:0] sp_ff, sp_in, spm1, spm2, slots, slots_new;
   logic [12:0]    pc_ff, pc_in;
   logic [7:0]     nv_ff, nv_in;
   logic [12:0]    plen_ff, plen_in, plen_w;
   logic           fill_act_ff, fill_act_in;
   logic [SPW-1:0] fill_cnt_ff, fill_cnt_in;
   logic           fill_we;

   logic           rv_valid_ff, rv_valid_in;
   logic [12:0]    o_pc_ff;
   logic           o_wv_ff, o_nl_ff;
   logic [31:0]    o_wval_ff;
   logic [2:0]     o_st_ff;

   logic [31:0]    sp32, quotient, alu_r;
   logic           div_busy, sp_full, faulty;
   logic           wr_en, mem_we;
   logic [AW-1:0]  wr_addr, mem_waddr;
   logic [31:0]    wr_data, mem_wdata;
   logic [SPW-1:0] sp_next;
   logic [12:0]    npc;
   logic [2:0]     st;
   logic           wv, nl;
   logic [31:0]    wval;

   function automatic logic is_true(input logic [31:0] v);
      return (v != 32'd0) && !v[31];
   endfunction

   assign spm1    = sp_ff - SPW'(1);
   assign spm2    = sp_ff - SPW'(2);
   assign sp32    = 32'(sp_ff);
   assign sp_full = sp32 >= STACK_DEPTH;

   // Variable slot counts, limited to the stack depth
   assign slots     = (32'(nv_ff) > STACK_DEPTH) ? SPW'(STACK_DEPTH) : SPW'(nv_ff);
   assign slots_new = (32'(csr_data[7:0]) > STACK_DEPTH) ? SPW'(STACK_DEPTH)
                                                          : SPW'(csr_data[7:0]);

   // Program length clamped to 1..PROG_DEPTH
   always_comb begin
      plen_w = csr_data[12:0];
      if (plen_w == 13'd0) begin
         plen_w = 13'd1;
      end else if (32'(plen_w) > PROG_DEPTH) begin
         plen_w = 13'(PROG_DEPTH);
      end
   end

   // Stack read address: first word, then second (indirect for NEG/INC/DEC)
   always_comb begin
      if (cmd.rd2) begin
         unique case (op_ff) inside
            psm_pkg::OP_NEG, psm_pkg::OP_INC, psm_pkg::OP_DEC: rd_addr = rdata_ff[AW-1:0];
            default: rd_addr = spm1[AW-1:0];
         endcase
      end else begin
         unique case (op_ff) inside
            psm_pkg::OP_LDV: rd_addr = opd_ff[AW-1:0];
            [psm_pkg::OP_SUP:psm_pkg::OP_OR], [psm_pkg::OP_ADD:psm_pkg::OP_MULT],
            psm_pkg::OP_AFF: rd_addr = spm2[AW-1:0];
            default: rd_addr = spm1[AW-1:0];
         endcase
      end
   end

   psm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (a_ff),
      .divisor  (b_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // Two-operand results
   always_comb begin
      unique case (op_ff)
         psm_pkg::OP_SUP:   alu_r = 32'($signed(b_ff) < $signed(a_ff));
         psm_pkg::OP_SUPE:  alu_r = 32'(!($signed(a_ff) < $signed(b_ff)));
         psm_pkg::OP_INF:   alu_r = 32'($signed(a_ff) < $signed(b_ff));
         psm_pkg::OP_INFE:  alu_r = 32'(!($signed(b_ff) < $signed(a_ff)));
         psm_pkg::OP_EG:    alu_r = 32'(a_ff == b_ff);
         psm_pkg::OP_DIFF:  alu_r = 32'(a_ff != b_ff);
         psm_pkg::OP_AND:   alu_r = 32'(is_true(a_ff) && is_true(b_ff));
         psm_pkg::OP_OR:    alu_r = 32'(is_true(a_ff) || is_true(b_ff));
         psm_pkg::OP_ADD:   alu_r = a_ff + b_ff;
         psm_pkg::OP_MOINS: alu_r = a_ff - b_ff;
         psm_pkg::OP_DIV:   alu_r = quotient;
         default:           alu_r = a_ff * b_ff;
      endcase
   end

   // Execute: fault checks, write back, next pc and status
   always_comb begin
      npc     = pc_ff + 13'd1;
      st      = psm_pkg::ST_RUN;
      wr_en   = 1'b0;
      wr_addr = sp_ff[AW-1:0];
      wr_data = alu_r;
      sp_next = sp_ff;
      wv      = 1'b0;
      wval    = 32'd0;
      nl      = 1'b0;
      unique case (op_ff) inside
         psm_pkg::OP_LDA, psm_pkg::OP_LDV, psm_pkg::OP_LDC, psm_pkg::OP_TSR,
         psm_pkg::OP_RD, psm_pkg::OP_RDLN: begin
            if (sp_full || (op_ff == psm_pkg::OP_LDV && opd_ff >= sp32)) begin
               st = psm_pkg::ST_STACK_FAULT;
            end else begin
               wr_en   = 1'b1;
               sp_next = sp_ff + SPW'(1);
               if (op_ff == psm_pkg::OP_TSR) begin
                  wr_data = 32'(pc_ff);
                  npc     = opd_ff[12:0];
               end else if (op_ff == psm_pkg::OP_RD || op_ff == psm_pkg::OP_RDLN) begin
                  wr_data = rv_ff;
                  nl      = (op_ff == psm_pkg::OP_RDLN);
               end else begin
                  wr_data = (op_ff == psm_pkg::OP_LDV) ? a_ff : opd_ff;
                  npc     = pc_ff + 13'd2;
               end
            end
         end
         [psm_pkg::OP_SUP:psm_pkg::OP_OR], [psm_pkg::OP_ADD:psm_pkg::OP_MULT]: begin
            if (sp_ff < SPW'(2)) begin
               st = psm_pkg::ST_STACK_FAULT;
            end else if (op_ff == psm_pkg::OP_DIV && b_ff == 32'd0) begin
               st = psm_pkg::ST_DIV_ZERO;
            end else begin
               wr_en   = 1'b1;
               wr_addr = spm2[AW-1:0];
               sp_next = spm1;
            end
         end
         psm_pkg::OP_NOT: begin
            if (sp_ff == '0) begin
               st = psm_pkg::ST_STACK_FAULT;
            end else begin
               wr_en   = 1'b1;
               wr_addr = spm1[AW-1:0];
               wr_data = 32'(!is_true(a_ff));
            end
         end
         psm_pkg::OP_JMP: npc = opd_ff[12:0];
         psm_pkg::OP_JIF: begin
            if (sp_ff == '0) begin
               st = psm_pkg::ST_STACK_FAULT;
            end else begin
               sp_next = spm1;
               npc     = is_true(a_ff) ? pc_ff + 13'd2 : opd_ff[12:0];
            end
         end
         psm_pkg::OP_RSR: begin
            if (sp_ff == '0) begin
               st = psm_pkg::ST_STACK_FAULT;
            end else begin
               sp_next = spm1;
               npc     = a_ff[12:0] + 13'd2;
            end
         end
         psm_pkg::OP_NEG, psm_pkg::OP_INC, psm_pkg::OP_DEC: begin
            if (sp_ff == '0 || a_ff >= sp32 - 32'd1) begin
               st = psm_pkg::ST_STACK_FAULT;
            end else if (op_ff == psm_pkg::OP_NEG) begin
               wr_en   = 1'b1;
               wr_addr = a_ff[AW-1:0];
               wr_data = 32'd0 - b_ff;
               sp_next = spm1;
            end else begin
               wr_en   = 1'b1;
               wr_addr = spm1[AW-1:0];
               wr_data = (op_ff == psm_pkg::OP_INC) ? b_ff + 32'd1 : b_ff - 32'd1;
            end
         end
         psm_pkg::OP_WRT, psm_pkg::OP_WRTLN: begin
            if (sp_ff == '0) begin
               st = psm_pkg::ST_STACK_FAULT;
            end else begin
               sp_next = spm1;
               wv      = 1'b1;
               wval    = a_ff;
               nl      = (op_ff == psm_pkg::OP_WRTLN);
            end
         end
         psm_pkg::OP_AFF: begin
            if (sp_ff < SPW'(2) || a_ff >= sp32 - 32'd2) begin
               st = psm_pkg::ST_STACK_FAULT;
            end else begin
               wr_en   = 1'b1;
               wr_addr = a_ff[AW-1:0];
               wr_data = b_ff;
               sp_next = spm2;
            end
         end
         default: begin
            // Stop: check stack at variables and pc at the last word
            if (sp_ff != slots) begin
               st = (pc_ff != plen_ff - 13'd1) ? psm_pkg::ST_BAD_BOTH
                                               : psm_pkg::ST_BAD_STACK;
            end else begin
               st = (pc_ff != plen_ff - 13'd1) ? psm_pkg::ST_BAD_CODE
                                               : psm_pkg::ST_CLEAN;
            end
            npc = plen_ff;
         end
      endcase
      faulty = (st == psm_pkg::ST_STACK_FAULT) || (st == psm_pkg::ST_DIV_ZERO);
      if (faulty) begin
         npc     = pc_ff;
         wr_en   = 1'b0;
         sp_next = sp_ff;
         wv      = 1'b0;
         wval    = 32'd0;
         nl      = 1'b0;
      end
   end

   // Write port: fill sweep or instruction write back
   assign fill_we   = fill_act_ff && (fill_cnt_ff != slots);
   assign mem_we    = fill_we || (cmd.commit && wr_en);
   assign mem_waddr = fill_we ? fill_cnt_ff[AW-1:0] : wr_addr;
   assign mem_wdata = fill_we ? psm_pkg::VAR_INIT : wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[rd_addr];
   end

   // Control state next values
   always_comb begin
      sp_in       = sp_ff;
      pc_in       = pc_ff;
      nv_in       = nv_ff;
      plen_in     = plen_ff;
      fill_act_in = fill_act_ff;
      fill_cnt_in = fill_cnt_ff;
      rv_valid_in = rv_valid_ff;
      if (fill_act_ff) begin
         if (fill_we) begin
            fill_cnt_in = fill_cnt_ff + SPW'(1);
         end else begin
            fill_act_in = 1'b0;
         end
      end
      if (rv_valid_ff && rsp_tready) begin
         rv_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         sp_in       = sp_next;
         pc_in       = npc;
         rv_valid_in = 1'b1;
      end
      if (csr_write && csr_index == psm_pkg::CSR_NUM_VARIABLES) begin
         nv_in       = csr_data[7:0];
         sp_in       = slots_new;
         pc_in       = 13'd0;
         fill_act_in = 1'b1;
         fill_cnt_in = '0;
      end else if (csr_write && csr_index == psm_pkg::CSR_PROGRAM_LENGTH) begin
         plen_in = plen_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff       <= '0;
         pc_ff       <= 13'd0;
         nv_ff       <= 8'd0;
         plen_ff     <= 13'd1;
         fill_act_ff <= 1'b0;
         fill_cnt_ff <= '0;
         rv_valid_ff <= 1'b0;
      end else begin
         sp_ff       <= sp_in;
         pc_ff       <= pc_in;
         nv_ff       <= nv_in;
         plen_ff     <= plen_in;
         fill_act_ff <= fill_act_in;
         fill_cnt_ff <= fill_cnt_in;
         rv_valid_ff <= rv_valid_in;
      end
   end

   // Instruction, operand and result registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_opcode;
         opd_ff <= req_operand;
         rv_ff  <= req_read_value;
      end
      if (cmd.rd2) begin
         a_ff <= rdata_ff;
      end
      if (cmd.cap_b) begin
         b_ff <= rdata_ff;
      end
      if (cmd.commit) begin
         o_pc_ff   <= npc;
         o_wv_ff   <= wv;
         o_wval_ff <= wval;
         o_nl_ff   <= nl;
         o_st_ff   <= st;
      end
   end

   assign status.fill_busy = fill_act_ff;
   assign status.op_is_div = (op_ff == psm_pkg::OP_DIV);
   assign status.div_busy  = div_busy;
   assign status.out_free  = !rv_valid_ff || rsp_tready;

   assign rsp_valid       = rv_valid_ff;
   assign rsp_next_pc     = o_pc_ff;
   assign rsp_write_valid = o_wv_ff;
   assign rsp_write_value = o_wval_ff;
   assign rsp_newline     = o_nl_ff;
   assign rsp_status      = o_st_ff;

endmodule

[rtl/pcode_stack_machine.sv]
// ----------------------------------------------------------------------------
// pcode_stack_machine: P-code stack machine, one instruction per transfer
// Executes each instruction against a stack of 32-bit words and returns the
// next pc, any write output and a status.
// ----------------------------------------------------------------------------
// Usage:
//  req_ channel carries one instruction per transfer; rsp_ returns exactly
//  one result per instruction, in order. csr_ writes num_variables (index 0)
//  or program_length (index 1); csr_ready is always high.
//  Most opcodes step through two reads of the single-read-port stack
//  memory, then write back; DIV adds a divide in which the divider
//  resolves one quotient bit per cycle.
//  One instruction is in flight at a time; the next req transfer is taken
//  once the previous result sits in the output register, so one result may
//  wait on rsp while the next instruction runs. A stalled rsp holds the
//  retire step of the following instruction.
//  Reset: stack pointer and pc zero, num_variables 0, program_length 1.
//  Writing num_variables restarts the machine and sweeps -666 into the
//  variable slots, one per cycle, with req_tready low meanwhile.
// ----------------------------------------------------------------------------
module pcode_stack_machine #(
   parameter int STACK_DEPTH = 256,
   parameter int PROG_DEPTH  = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] operand, [63:32] read_value
   input  logic [4:0]  req_tuser,   // [4:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [12:0] next_pc, [44:13] write_value, zero pad
   output logic [4:0]  rsp_tuser,   // [0] write_valid, [1] newline, [4:2] status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);

   psm_pkg::ctrl_cmd_type  cmd;
   psm_pkg::dp_status_type status;
   logic [12:0]            next_pc;
   logic signed [31:0]     write_value;

   assign csr_ready = 1'b1;

   psm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   psm_dpath #(
      .STACK_DEPTH (STACK_DEPTH),
      .PROG_DEPTH  (PROG_DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_opcode      (req_tuser),
      .req_operand     (req_tdata[31:0]),
      .req_read_value  (req_tdata[63:32]),
      .csr_write       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_tready      (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .rsp_next_pc     (next_pc),
      .rsp_write_valid (rsp_tuser[0]),
      .rsp_write_value (write_value),
      .rsp_newline     (rsp_tuser[1]),
      .rsp_status      (rsp_tuser[4:2])
   );

   assign rsp_tdata = {3'b000, write_value, next_pc};

   // One instruction in flight: no back-to-back req transfers
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req transfer accepted while an instruction is in flight");

   // A restart blocks instructions until the variable sweep is done
   a_restart_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && csr_index == psm_pkg::CSR_NUM_VARIABLES |=> !req_tready)
      else $error("req ready during variable fill");

   // A result is only loaded while the result register is free
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.out_free)
      else $error("result register overwritten");

endmodule
